// File: rtl/core/sha256_byte_stream_hasher_unit_macros.svh
// Assertion macros shared by the SHA-256 hasher checkers.
// Expects clk and rst_n to be visible in the scope that expands them.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define SHA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/sha256_pkg.sv
// Shared types and constants for the SHA-256 byte-stream hasher.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package sha256_pkg;

  localparam int unsigned CNT_W     = 61;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned RND_W     = 6;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned WORDS     = 16;
  localparam int unsigned HASH_WDS  = 8;

  localparam logic [RND_W-1:0] LAST_ROUND   = 6'd63;
  localparam logic [POS_W-1:0] LAST_POS     = 6'd63;
  localparam logic [POS_W-1:0] LEN_POS      = 6'd56;
  localparam logic [IDX_W-1:0] LAST_IDX     = 3'd7;
  localparam logic [7:0]       PAD_BYTE     = 8'h80;

  localparam logic [31:0] INIT_HASH [HASH_WDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_FOLD  = 5'b00100,
    ST_PAD2  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic             absorb;
    logic             pad;
    logic             pad2;
    logic             load;
    logic             round;
    logic             fold;
    logic             shift;
    logic             clear;
    logic [RND_W-1:0] rnd;
  } cmd_t;

  typedef struct packed {
    logic blk_last;
    logic pad_late;
  } sts_t;

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] v);
    return ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] v);
    return ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] v);
    return ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] v);
    return ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sha256_in_if.sv
// Input channel of the SHA-256 hasher: valid/ready plus op and data byte.
// Standalone; no package dependency.
`default_nettype none

interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sha256_out_if.sv
// Result channel of the SHA-256 hasher: valid/ready plus one digest word.
// Standalone; no package dependency.
`default_nettype none

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/sha256_dp.sv
// Datapath: message window, working variables, chaining words and byte count.
// Depends on sha256_pkg; driven by commands from sha256_ctrl.
`default_nettype none

module sha256_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sha256_pkg::cmd_t   cmd,
  input  logic [7:0]         data_byte,
  output sha256_pkg::sts_t   sts,
  output logic [31:0]        digest_word
);
  import sha256_pkg::*;

  logic [31:0]      w_r   [WORDS];
  logic [31:0]      w_nxt [WORDS];
  logic [31:0]      wk_r  [HASH_WDS];
  logic [31:0]      wk_nxt[HASH_WDS];
  logic [31:0]      cv_r  [HASH_WDS];
  logic [31:0]      cv_nxt[HASH_WDS];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [POS_W-1:0] pos;
  logic [63:0]      bits;
  logic [31:0]      t1;
  logic [31:0]      t2;
  logic [31:0]      w_new;

  assign pos          = cnt_r[POS_W-1:0];
  assign bits         = {cnt_r, 3'b000};
  assign sts.blk_last = (pos == LAST_POS);
  assign sts.pad_late = (pos >= LEN_POS);
  assign digest_word  = cv_r[0];

  assign t1 = wk_r[7] + bsig1(wk_r[4]) + ((wk_r[4] & wk_r[5]) ^ (~wk_r[4] & wk_r[6]))
            + ROUND_K[cmd.rnd] + w_r[0];
  assign t2 = bsig0(wk_r[0]) + ((wk_r[0] & wk_r[1]) ^ (wk_r[0] & wk_r[2]) ^ (wk_r[1] & wk_r[2]));
  assign w_new = w_r[0] + ssig0(w_r[1]) + w_r[9] + ssig1(w_r[14]);

  always_comb begin
    w_nxt   = w_r;
    wk_nxt  = wk_r;
    cv_nxt  = cv_r;
    cnt_nxt = cnt_r;

    if (cmd.absorb) begin
      unique case (pos[1:0])
        2'd0:    w_nxt[pos[5:2]][31:24] = data_byte;
        2'd1:    w_nxt[pos[5:2]][23:16] = data_byte;
        2'd2:    w_nxt[pos[5:2]][15:8]  = data_byte;
        default: w_nxt[pos[5:2]][7:0]   = data_byte;
      endcase
      cnt_nxt = cnt_r + 61'd1;
    end

    if (cmd.pad) begin
      for (int j = 0; j < 64; j++) begin
        if (POS_W'(j) == pos) begin
          w_nxt[j / 4][31 - 8 * (j % 4) -: 8] = PAD_BYTE;
        end else if (POS_W'(j) > pos) begin
          w_nxt[j / 4][31 - 8 * (j % 4) -: 8] = 8'h00;
        end
      end
      if (!sts.pad_late) begin
        w_nxt[14] = bits[63:32];
        w_nxt[15] = bits[31:0];
      end
    end

    if (cmd.pad2) begin
      for (int j = 0; j < 14; j++) begin
        w_nxt[j] = 32'h0;
      end
      w_nxt[14] = bits[63:32];
      w_nxt[15] = bits[31:0];
    end

    if (cmd.load) begin
      wk_nxt = cv_r;
    end

    if (cmd.round) begin
      for (int j = 0; j < 15; j++) begin
        w_nxt[j] = w_r[j + 1];
      end
      w_nxt[15] = w_new;
      wk_nxt[0] = t1 + t2;
      wk_nxt[1] = wk_r[0];
      wk_nxt[2] = wk_r[1];
      wk_nxt[3] = wk_r[2];
      wk_nxt[4] = wk_r[3] + t1;
      wk_nxt[5] = wk_r[4];
      wk_nxt[6] = wk_r[5];
      wk_nxt[7] = wk_r[6];
    end

    if (cmd.fold) begin
      for (int j = 0; j < 8; j++) begin
        cv_nxt[j] = cv_r[j] + wk_r[j];
      end
    end

    if (cmd.shift) begin
      for (int j = 0; j < 7; j++) begin
        cv_nxt[j] = cv_r[j + 1];
      end
      cv_nxt[7] = cv_r[0];
    end

    if (cmd.clear) begin
      cv_nxt  = INIT_HASH;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r  <= INIT_HASH;
      cnt_r <= '0;
    end else begin
      cv_r  <= cv_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r  <= w_nxt;
    wk_r <= wk_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/sha256_ctrl.sv
// Controller: one-hot sequencer for absorb, rounds, padding and digest output.
// Depends on sha256_pkg; issues commands to sha256_dp.
`default_nettype none

module sha256_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_op,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sha256_pkg::IDX_W-1:0] word_index,
  output logic                       last_word,
  input  sha256_pkg::sts_t           sts,
  output sha256_pkg::cmd_t           cmd
);
  import sha256_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  logic [RND_W-1:0] rnd_r;
  logic [RND_W-1:0] rnd_nxt;
  logic             fin_r;
  logic             fin_nxt;
  logic             two_r;
  logic             two_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             acc_in;
  logic             acc_out;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = (state_r == ST_EMIT);
  assign acc_in     = in_valid & in_ready;
  assign acc_out    = out_valid & out_ready;
  assign word_index = idx_r;
  assign last_word  = (idx_r == LAST_IDX);

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    fin_nxt   = fin_r;
    two_nxt   = two_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.rnd   = rnd_r;

    unique case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          rnd_nxt = '0;
          if (!in_op) begin
            cmd.absorb = 1'b1;
            if (sts.blk_last) begin
              cmd.load  = 1'b1;
              state_nxt = ST_ROUND;
            end
          end else begin
            cmd.pad   = 1'b1;
            cmd.load  = 1'b1;
            fin_nxt   = 1'b1;
            two_nxt   = sts.pad_late;
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        priority if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (two_r) begin
          two_nxt   = 1'b0;
          state_nxt = ST_PAD2;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_PAD2: begin
        cmd.pad2  = 1'b1;
        cmd.load  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_EMIT: begin
        if (acc_out) begin
          cmd.shift = 1'b1;
          idx_nxt   = idx_r + 3'd1;
          if (idx_r == LAST_IDX) begin
            cmd.clear = 1'b1;
            fin_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      fin_r   <= 1'b0;
      two_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      fin_r   <= fin_nxt;
      two_r   <= two_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sha256_byte_stream_hasher_unit.sv
// Top level of the SHA-256 byte-stream hasher: controller plus datapath.
// Depends on sha256_pkg, sha256_in_if, sha256_out_if, sha256_ctrl, sha256_dp.
//
//   channel  dir  fields                                  transaction
//   in_ch    in   op, data_byte                           one byte or a finish
//   out_ch   out  digest_word, word_index, last_word      one digest word
//
// A data byte leaves in_ready high; the 64th byte of a block holds in_ready low
// through the 64 rounds of the single round unit and the chaining add. A finish
// runs rounds and chaining add on the padded block and on an extra length block
// if needed, then eight digest words at one per cycle while out_ready is high.
// Reset is synchronous: chaining words return to the initial hash, count to zero.
// Low out_ready holds the current word; in_ready stays low until word 7 is taken.
`default_nettype none

module sha256_byte_stream_hasher_unit (
  input  logic                clk,
  input  logic                rst_n,
  sha256_in_if.sink           in_ch,
  sha256_out_if.source        out_ch
);
  import sha256_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [31:0]       digest_word;
  logic [IDX_W-1:0]  word_index;
  logic              last_word;
  logic              in_ready;
  logic              out_valid;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_op      (in_ch.op),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .word_index (word_index),
    .last_word  (last_word),
    .sts        (sts),
    .cmd        (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_ch.data_byte),
    .sts         (sts),
    .digest_word (digest_word)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.digest_word = digest_word;
  assign out_ch.word_index  = word_index;
  assign out_ch.last_word   = last_word;

endmodule

`default_nettype wire

// File: rtl/core/sha256_chk.sv
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Depends on sha256_byte_stream_hasher_unit_macros.svh.
`default_nettype none

`include "sha256_byte_stream_hasher_unit_macros.svh"

module sha256_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  `SHA_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index),
    "stalled digest word changed")
  `SHA_ASSERT(a_last_flag,
    out_valid |-> (last_word == (word_index == 3'd7)),
    "last_word disagrees with word_index")
  `SHA_ASSERT(a_idx_step,
    out_valid && out_ready && !last_word |=> out_valid && (word_index == $past(word_index) + 3'd1),
    "digest words out of sequence")
  `SHA_ASSERT(a_last_done,
    out_valid && out_ready && last_word |=> !out_valid && in_ready,
    "digest burst did not end after last word")
  `SHA_NEVER(a_no_overlap, in_ready && out_valid, "input taken while digest pending")

endmodule

bind sha256_byte_stream_hasher_unit sha256_chk u_sha256_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .digest_word (out_ch.digest_word),
  .word_index  (out_ch.word_index),
  .last_word   (out_ch.last_word)
);

`default_nettype wire
